/* hw/rtl/stke_pkg.sv */
// Shared types, widths and tap constants for the smooth Teager-Kaiser energy block.
// Used by stke_cell, stke_part and smooth_teager_kaiser_energy_top; no dependencies.

package stke_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int TAPS         = 11;
    localparam int CENTRE       = 5;
    localparam int COEF_W       = 8;
    localparam int PROD_W       = SAMPLE_WIDTH + COEF_W;
    localparam int SUM_W        = SAMPLE_WIDTH + 8;
    localparam int SQ_W         = 2 * SUM_W;
    localparam int XS_W         = SAMPLE_WIDTH + SUM_W;
    localparam int PART_W       = 2 * SAMPLE_WIDTH + 20;
    localparam int ACC_W        = PART_W + 1;
    localparam int ENERGY_W     = 53;
    localparam int EXT_W        = (ACC_W > ENERGY_W) ? ACC_W : ENERGY_W;
    localparam int FILL_W       = 3;

    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(6);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]       coef_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [SUM_W-1:0]        sum_t;
    typedef logic signed [SQ_W-1:0]         sq_t;
    typedef logic signed [XS_W-1:0]         xs_t;
    typedef logic signed [PART_W-1:0]       part_t;
    typedef logic signed [EXT_W-1:0]        ext_t;
    typedef logic signed [ENERGY_W-1:0]     energy_t;

    // Stage load enables handed from the top-level flow control to each part.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } adv_t;

    // Taps indexed by delay-line position, position 0 holding the newest sample.
    localparam coef_t D1_TAPS [TAPS] = '{
        8'sd1, 8'sd8, 8'sd27, 8'sd48, 8'sd42, 8'sd0,
        -8'sd42, -8'sd48, -8'sd27, -8'sd8, -8'sd1
    };

    localparam coef_t D2_TAPS [TAPS] = '{
        8'sd0, -8'sd7, 8'sd12, 8'sd52, -8'sd12, -8'sd90,
        -8'sd12, 8'sd52, 8'sd12, -8'sd7, 8'sd0
    };

    localparam energy_t E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam energy_t E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    function automatic energy_t saturate(ext_t v);
        energy_t r;
        if (v > ext_t'(E_MAX))
        begin
            r = E_MAX;
        end
        else if (v < ext_t'(E_MIN))
        begin
            r = E_MIN;
        end
        else
        begin
            r = v[ENERGY_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/stke_cell.sv */
// One cell of the delay line: holds one real and one imaginary sample and their
// products with the two derivative taps. Depends on stke_pkg.

module stke_cell
    import stke_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift,
    input  sample_t re_in,
    input  sample_t im_in,
    input  coef_t   c1,
    input  coef_t   c2,
    output sample_t re_tap,
    output sample_t im_tap,
    output prod_t   re_p1,
    output prod_t   re_p2,
    output prod_t   im_p1,
    output prod_t   im_p2
);

    sample_t re_tap_reg;
    sample_t im_tap_reg;
    prod_t   re_p1_reg;
    prod_t   re_p2_reg;
    prod_t   im_p1_reg;
    prod_t   im_p2_reg;

    // The products always match the stored samples, so the zero padding after
    // reset also carries zero products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_tap_reg <= '0;
            im_tap_reg <= '0;
            re_p1_reg  <= '0;
            re_p2_reg  <= '0;
            im_p1_reg  <= '0;
            im_p2_reg  <= '0;
        end
        else if (shift)
        begin
            re_tap_reg <= re_in;
            im_tap_reg <= im_in;
            re_p1_reg  <= prod_t'(re_in) * prod_t'(c1);
            re_p2_reg  <= prod_t'(re_in) * prod_t'(c2);
            im_p1_reg  <= prod_t'(im_in) * prod_t'(c1);
            im_p2_reg  <= prod_t'(im_in) * prod_t'(c2);
        end
    end

    assign re_tap = re_tap_reg;
    assign im_tap = im_tap_reg;
    assign re_p1  = re_p1_reg;
    assign re_p2  = re_p2_reg;
    assign im_p1  = im_p1_reg;
    assign im_p2  = im_p2_reg;

endmodule

/* hw/rtl/stke_part.sv */
// Energy of one signal part: sums the cell products into both derivatives, squares
// and multiplies, then forms 3*S1*S1 - 4096*x*S2. Depends on stke_pkg.

module stke_part
    import stke_pkg::*;
(
    input  logic    clk,
    input  adv_t    adv,
    input  prod_t   p1 [TAPS],
    input  prod_t   p2 [TAPS],
    input  sample_t centre,
    output part_t   energy
);

    sum_t    s1_next;
    sum_t    s2_next;
    sum_t    s1_reg;
    sum_t    s2_reg;
    sample_t x_reg;
    sq_t     sq_reg;
    xs_t     xs_reg;
    part_t   e_reg;

    always_comb
    begin
        s1_next = '0;
        s2_next = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            s1_next = s1_next + sum_t'(p1[i]);
            s2_next = s2_next + sum_t'(p2[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.ld1)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            x_reg  <= centre;
        end
        if (adv.ld2)
        begin
            sq_reg <= sq_t'(s1_reg) * sq_t'(s1_reg);
            xs_reg <= xs_t'(x_reg) * xs_t'(s2_reg);
        end
        if (adv.ld3)
        begin
            e_reg <= (part_t'(sq_reg) <<< 1) + part_t'(sq_reg) - (part_t'(xs_reg) <<< 12);
        end
    end

    assign energy = e_reg;

endmodule

/* hw/rtl/smooth_teager_kaiser_energy_top.sv */
// Top level of the smooth Teager-Kaiser energy block: delay-line cells, two part
// pipelines and the flow control. Depends on stke_pkg, stke_cell and stke_part.
//
//  Channel   Handshake                     Payload
//  sample    sample_valid / sample_stall   sample_re, sample_im
//  result    result_valid / result_stall   energy, warm
//  config    cfg_write                     cfg_data (complex_mode)
//
// One sample is taken per clock while sample_stall is low; each result passes through
// five registered stages: cells, derivative sums, multipliers, part energies and the
// output register. Reset clears the delay line to zeros (the leading padding), the
// fill count and complex_mode. A stalled result holds only the stages behind it that
// are full; empty stages keep taking samples.

module smooth_teager_kaiser_energy_top
    import stke_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample_re,
    input  sample_t sample_im,
    output logic    result_valid,
    input  logic    result_stall,
    output energy_t energy,
    output logic    warm,
    input  logic    cfg_write,
    input  logic    cfg_data
);

    logic              mode_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              v0_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              v4_reg;
    logic              w0_reg;
    logic              w1_reg;
    logic              w2_reg;
    logic              w3_reg;
    logic              warm_reg;
    energy_t           energy_reg;
    logic              rdy0;
    logic              rdy1;
    logic              rdy2;
    logic              rdy3;
    logic              rdy4;
    logic              accept;
    adv_t              adv;

    sample_t re_tap [TAPS];
    sample_t im_tap [TAPS];
    prod_t   re_p1  [TAPS];
    prod_t   re_p2  [TAPS];
    prod_t   im_p1  [TAPS];
    prod_t   im_p2  [TAPS];
    part_t   re_energy;
    part_t   im_energy;
    ext_t    total;

    // A stage may load when it is empty or when the stage after it loads.
    assign rdy4 = !v4_reg || !result_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign accept       = sample_valid && rdy0;
    assign sample_stall = !rdy0;

    assign adv.ld1 = rdy1;
    assign adv.ld2 = rdy2;
    assign adv.ld3 = rdy3;

    assign fill_next = (fill_reg < FULL_FILL) ? fill_reg + FILL_W'(1) : fill_reg;

    genvar g;
    generate
        for (g = 0; g < TAPS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                stke_cell u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .shift  (accept),
                    .re_in  (sample_re),
                    .im_in  (sample_im),
                    .c1     (D1_TAPS[g]),
                    .c2     (D2_TAPS[g]),
                    .re_tap (re_tap[g]),
                    .im_tap (im_tap[g]),
                    .re_p1  (re_p1[g]),
                    .re_p2  (re_p2[g]),
                    .im_p1  (im_p1[g]),
                    .im_p2  (im_p2[g])
                );
            end
            else
            begin : g_body
                stke_cell u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .shift  (accept),
                    .re_in  (re_tap[g-1]),
                    .im_in  (im_tap[g-1]),
                    .c1     (D1_TAPS[g]),
                    .c2     (D2_TAPS[g]),
                    .re_tap (re_tap[g]),
                    .im_tap (im_tap[g]),
                    .re_p1  (re_p1[g]),
                    .re_p2  (re_p2[g]),
                    .im_p1  (im_p1[g]),
                    .im_p2  (im_p2[g])
                );
            end
        end
    endgenerate

    stke_part u_part_re (
        .clk    (clk),
        .adv    (adv),
        .p1     (re_p1),
        .p2     (re_p2),
        .centre (re_tap[CENTRE]),
        .energy (re_energy)
    );

    stke_part u_part_im (
        .clk    (clk),
        .adv    (adv),
        .p1     (im_p1),
        .p2     (im_p2),
        .centre (im_tap[CENTRE]),
        .energy (im_energy)
    );

    assign total = ext_t'(re_energy) + (mode_reg ? ext_t'(im_energy) : ext_t'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            fill_reg <= '0;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            w0_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
            if (accept)
            begin
                fill_reg <= fill_next;
                w0_reg   <= (fill_next >= FULL_FILL);
                v0_reg   <= 1'b1;
            end
            else if (rdy1)
            begin
                v0_reg <= 1'b0;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // The warm flag rides alongside the data; leading padding gives zero energy.
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            w1_reg <= w0_reg;
        end
        if (rdy2)
        begin
            w2_reg <= w1_reg;
        end
        if (rdy3)
        begin
            w3_reg <= w2_reg;
        end
        if (rdy4)
        begin
            warm_reg   <= w3_reg;
            energy_reg <= w3_reg ? saturate(total) : '0;
        end
    end

    assign result_valid = v4_reg;
    assign energy       = energy_reg;
    assign warm         = warm_reg;

endmodule
